[hdl/sorted_retry_timer_queue_defines.svh]
// Assertion macros shared by the timer queue RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef SORTED_RETRY_TIMER_QUEUE_DEFINES_SVH
`define SORTED_RETRY_TIMER_QUEUE_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define SRTQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define SRTQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/srtq_pkg.sv]
// Types and constants of the sorted retry timer queue.
// No dependencies; imported by sorted_retry_timer_queue and srtq_ctrl.
`default_nettype none

package srtq_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int ENTRY_W     = 64;

    typedef enum logic [1:0] {
        ACT_PUSH   = 2'd0,
        ACT_POP    = 2'd1,
        ACT_REMOVE = 2'd2,
        ACT_EXPIRE = 2'd3
    } act_t;

    typedef enum logic [3:0] {
        KIND_PUSH_OK   = 4'd0,
        KIND_FULL      = 4'd1,
        KIND_CLOSED    = 4'd2,
        KIND_POPPED    = 4'd3,
        KIND_NOT_FOUND = 4'd4,
        KIND_REMOVED   = 4'd5,
        KIND_RETRY     = 4'd6,
        KIND_TIMEOUT   = 4'd7,
        KIND_EXP_END   = 4'd8
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT_RD,
        ST_EMIT_OUT,
        ST_COPY,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic [7:0]  conn;
        logic [7:0]  mtype;
        logic [15:0] retries;
        logic [31:0] deadline;
    } entry_t;

    typedef struct packed {
        act_t        action;
        logic [31:0] now_ms;
        logic [7:0]  conn_id;
        logic [7:0]  msg_type;
        logic [15:0] retries;
        logic [31:0] timeout_ms;
        logic        conn_open;
    } req_t;

    typedef struct packed {
        logic             valid;
        kind_t            kind;
        logic [7:0]       conn_id;
        logic [7:0]       msg_type;
        logic [15:0]      retries_left;
        logic [31:0]      next_wait_ms;
        logic [CNT_W-1:0] removed_count;
        logic             last;
    } res_t;

    // a is before b when a - b is negative as a signed 32-bit value
    function automatic logic wrap_before(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] diff;
        diff = a - b;
        return diff[31];
    endfunction

endpackage

`default_nettype wire

[hdl/sorted_retry_timer_queue.sv]
// Sequence: push, pop and remove sweep the table once before the result; a push
//   that is full or closed skips the sweep. Expire scans the due prefix, then reads
//   each expired timer from the RAM (one read each) and emits it, then copies the rest down.
// Throughput: one request at a time, set by the single read port of the table RAM.
// Reset: asynchronous, clears the entry count; the table RAM is not cleared.
// Top level of the sorted retry timer queue; depends on srtq_pkg and srtq_ctrl.
`default_nettype none

module sorted_retry_timer_queue
    import srtq_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // now_ms[31:0], conn_id[39:32], msg_type[47:40], retries[63:48],
    // timeout_ms[95:64], conn_open[96], zero fill
    input  wire logic [103:0] s_axis_tdata,
    // action[1:0]
    input  wire logic [1:0]   s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // out_conn_id[7:0], out_msg_type[15:8], retries_left[31:16],
    // next_wait_ms[63:32], removed_count[69:64], zero fill
    output logic [71:0]       m_axis_tdata,
    // kind[3:0]
    output logic [3:0]        m_axis_tuser,
    output logic              m_axis_tlast
);

    req_t  req;
    res_t  res;
    logic  res_free;
    logic  out_valid_reg;
    logic [71:0] out_data_reg;
    logic [3:0]  out_kind_reg;
    logic        out_last_reg;

    assign req.action     = act_t'(s_axis_tuser);
    assign req.now_ms     = s_axis_tdata[31:0];
    assign req.conn_id    = s_axis_tdata[39:32];
    assign req.msg_type   = s_axis_tdata[47:40];
    assign req.retries    = s_axis_tdata[63:48];
    assign req.timeout_ms = s_axis_tdata[95:64];
    assign req.conn_open  = s_axis_tdata[96];

    // output register takes a new result when empty or being drained
    assign res_free = !out_valid_reg || m_axis_tready;

    srtq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (s_axis_tvalid),
        .req       (req),
        .req_ready (s_axis_tready),
        .res_free  (res_free),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_free)
        begin
            out_valid_reg <= res.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_free && res.valid)
        begin
            out_data_reg <= {2'b00, 6'(res.removed_count), res.next_wait_ms,
                             res.retries_left, res.msg_type, res.conn_id};
            out_kind_reg <= res.kind;
            out_last_reg <= res.last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

`default_nettype wire

[hdl/srtq_ram.sv]
// Simple dual-port synchronous RAM: one write port, one registered read port.
// Generic; used as the timer table store.
`default_nettype none

module srtq_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 64,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[hdl/srtq_ctrl.sv]
// Sequencer of the timer queue: sweeps the table RAM for each request but a refused push.
// Depends on srtq_pkg, srtq_ram and the assertion macro header.
`default_nettype none
`include "sorted_retry_timer_queue_defines.svh"

module srtq_ctrl
    import srtq_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    input  wire req_t req,
    output logic      req_ready,
    input  wire logic res_free,
    output res_t      res
);

    state_t           state_reg, state_next;
    act_t             act_reg, act_next;
    logic [31:0]      now_reg, now_next;
    logic [7:0]       kconn_reg, kconn_next;
    logic [7:0]       ktype_reg, ktype_next;
    entry_t           new_reg, new_next;
    entry_t           hold_reg, hold_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] rd_reg, rd_next;
    logic [CNT_W-1:0] wr_reg, wr_next;
    logic [CNT_W-1:0] due_reg, due_next;
    logic [CNT_W-1:0] em_reg, em_next;
    logic [CNT_W-1:0] removed_reg, removed_next;
    logic             pend_reg, pend_next;
    logic [IDX_W-1:0] pidx_reg, pidx_next;
    logic             found_reg, found_next;
    logic [31:0]      wait_reg, wait_next;
    kind_t            kind_reg, kind_next;

    logic             mem_we, mem_re;
    logic [IDX_W-1:0] mem_waddr, mem_raddr;
    entry_t           mem_wdata, rd_entry;
    logic [ENTRY_W-1:0] rdata_raw;

    logic             accept, issue, sweep_done, full;
    logic [CNT_W-1:0] due_final;

    srtq_ram #(.DEPTH(TABLE_DEPTH), .WIDTH(ENTRY_W), .AW(IDX_W)) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (rdata_raw)
    );

    assign rd_entry   = rdata_raw;
    assign req_ready  = (state_reg == ST_IDLE);
    assign accept     = req_valid && req_ready;
    assign full       = (count_reg >= CNT_W'(TABLE_DEPTH));
    // expire stops reading once a timer that is not yet due has been seen
    assign issue      = (rd_reg < count_reg)
                        && ((state_reg == ST_COPY)
                            || (state_reg == ST_SCAN
                                && !(act_reg == ACT_EXPIRE && found_reg)));
    assign sweep_done = !pend_reg
                        && ((rd_reg == count_reg)
                            || (act_reg == ACT_EXPIRE && found_reg && state_reg == ST_SCAN));
    assign due_final  = found_reg ? due_reg : count_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (req.action == ACT_PUSH && (full || !req.conn_open))
                        state_next = ST_RESP;
                    else
                        state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (sweep_done)
                begin
                    if (act_reg == ACT_EXPIRE && due_final != '0)
                        state_next = ST_EMIT_RD;
                    else
                        state_next = ST_RESP;
                end
            end
            ST_EMIT_RD:
            begin
                state_next = ST_EMIT_OUT;
            end
            ST_EMIT_OUT:
            begin
                if (res_free)
                    state_next = (em_reg == CNT_W'(1)) ? ST_COPY : ST_EMIT_RD;
            end
            ST_COPY:
            begin
                if (sweep_done)
                    state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (res_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        act_next     = act_reg;
        now_next     = now_reg;
        kconn_next   = kconn_reg;
        ktype_next   = ktype_reg;
        new_next     = new_reg;
        hold_next    = hold_reg;
        count_next   = count_reg;
        rd_next      = rd_reg;
        wr_next      = wr_reg;
        due_next     = due_reg;
        em_next      = em_reg;
        removed_next = removed_reg;
        found_next   = found_reg;
        wait_next    = wait_reg;
        kind_next    = kind_reg;
        pend_next    = 1'b0;
        pidx_next    = pidx_reg;
        mem_we       = 1'b0;
        mem_waddr    = '0;
        mem_wdata    = rd_entry;
        mem_re       = 1'b0;
        mem_raddr    = rd_reg[IDX_W-1:0];
        res          = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    act_next              = req.action;
                    now_next              = req.now_ms;
                    kconn_next            = req.conn_id;
                    ktype_next            = req.msg_type;
                    new_next.conn         = req.conn_id;
                    new_next.mtype        = req.msg_type;
                    new_next.retries      = req.retries;
                    new_next.deadline     = req.now_ms + req.timeout_ms;
                    rd_next               = '0;
                    wr_next               = '0;
                    found_next            = 1'b0;
                    wait_next             = '0;
                    removed_next          = '0;
                    kind_next             = full ? KIND_FULL : KIND_CLOSED;
                end
            end
            ST_SCAN, ST_COPY:
            begin
                if (issue)
                begin
                    mem_re    = 1'b1;
                    pend_next = 1'b1;
                    pidx_next = rd_reg[IDX_W-1:0];
                    rd_next   = rd_reg + CNT_W'(1);
                end
                if (pend_reg && state_reg == ST_COPY)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = pidx_reg - due_reg[IDX_W-1:0];
                end
                else if (pend_reg)
                begin
                    case (act_reg)
                        ACT_PUSH:
                        begin
                            // carry the displaced entry one slot up
                            if (found_reg)
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = pidx_reg;
                                mem_wdata = hold_reg;
                                hold_next = rd_entry;
                            end
                            else if (new_reg.deadline == rd_entry.deadline
                                     || wrap_before(new_reg.deadline, rd_entry.deadline))
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = pidx_reg;
                                mem_wdata  = new_reg;
                                hold_next  = rd_entry;
                                found_next = 1'b1;
                            end
                        end
                        ACT_POP:
                        begin
                            if (found_reg)
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = pidx_reg - IDX_W'(1);
                            end
                            else if (rd_entry.conn == kconn_reg && rd_entry.mtype == ktype_reg)
                            begin
                                found_next = 1'b1;
                            end
                        end
                        ACT_REMOVE:
                        begin
                            if (rd_entry.conn != kconn_reg)
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = wr_reg[IDX_W-1:0];
                                wr_next   = wr_reg + CNT_W'(1);
                            end
                        end
                        default:
                        begin
                            if (!found_reg && wrap_before(now_reg, rd_entry.deadline))
                            begin
                                found_next = 1'b1;
                                due_next   = {1'b0, pidx_reg};
                                wait_next  = rd_entry.deadline - now_reg;
                            end
                        end
                    endcase
                end
                if (sweep_done && state_reg == ST_COPY)
                begin
                    count_next = count_reg - due_reg;
                    kind_next  = KIND_EXP_END;
                end
                else if (sweep_done)
                begin
                    case (act_reg)
                        ACT_PUSH:
                        begin
                            mem_we     = 1'b1;
                            mem_waddr  = count_reg[IDX_W-1:0];
                            mem_wdata  = found_reg ? hold_reg : new_reg;
                            count_next = count_reg + CNT_W'(1);
                            kind_next  = KIND_PUSH_OK;
                        end
                        ACT_POP:
                        begin
                            if (found_reg)
                                count_next = count_reg - CNT_W'(1);
                            kind_next = found_reg ? KIND_POPPED : KIND_NOT_FOUND;
                        end
                        ACT_REMOVE:
                        begin
                            removed_next = count_reg - wr_reg;
                            count_next   = wr_reg;
                            kind_next    = KIND_REMOVED;
                        end
                        default:
                        begin
                            due_next  = due_final;
                            em_next   = due_final;
                            kind_next = KIND_EXP_END;
                        end
                    endcase
                end
            end
            ST_EMIT_RD:
            begin
                mem_re    = 1'b1;
                mem_raddr = em_reg[IDX_W-1:0] - IDX_W'(1);
            end
            ST_EMIT_OUT:
            begin
                res.valid    = 1'b1;
                res.conn_id  = rd_entry.conn;
                res.msg_type = rd_entry.mtype;
                if (rd_entry.retries != '0)
                begin
                    res.kind         = KIND_RETRY;
                    res.retries_left = rd_entry.retries - 16'd1;
                end
                else
                begin
                    res.kind = KIND_TIMEOUT;
                end
                if (res_free)
                begin
                    em_next = em_reg - CNT_W'(1);
                    // copy the survivors down behind the expired prefix
                    rd_next = due_reg;
                end
            end
            ST_RESP:
            begin
                res.valid         = 1'b1;
                res.kind          = kind_reg;
                res.next_wait_ms  = wait_reg;
                res.removed_count = removed_reg;
                res.last          = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
            found_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg     <= act_next;
        now_reg     <= now_next;
        kconn_reg   <= kconn_next;
        ktype_reg   <= ktype_next;
        new_reg     <= new_next;
        hold_reg    <= hold_next;
        rd_reg      <= rd_next;
        wr_reg      <= wr_next;
        due_reg     <= due_next;
        em_reg      <= em_next;
        removed_reg <= removed_next;
        pidx_reg    <= pidx_next;
        wait_reg    <= wait_next;
        kind_reg    <= kind_next;
    end

    `SRTQ_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(TABLE_DEPTH),
        "entry count above table depth")
    `SRTQ_ASSERT_NOW(a_idle_quiet, clk, rst_n, state_reg == ST_IDLE,
        !mem_we && !pend_reg && !res.valid, "table or result activity while idle")
    `SRTQ_ASSERT_NEXT(a_emit_after_read, clk, rst_n, state_reg == ST_EMIT_RD,
        state_reg == ST_EMIT_OUT, "expired entry read not followed by its result")
    `SRTQ_ASSERT_NEXT(a_count_steady, clk, rst_n, state_reg == ST_EMIT_OUT
        || state_reg == ST_EMIT_RD || state_reg == ST_RESP,
        count_reg == $past(count_reg), "entry count changed outside a sweep")

endmodule

`default_nettype wire
